/* sv/fmbs_pkg.sv */
// shared types and constants of the fm-index backward search core
// no dependencies
package fmbs_pkg;

    localparam int ROWS_DEF     = 1024;
    localparam int SYMBOLS_DEF  = 8;
    localparam int MAX_HITS_DEF = 64;

    localparam int CFG_W = 11;
    localparam int ROW_W = 10;
    localparam int POS_W = 10;
    localparam int SYM_W = 3;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_PATTERN = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_HI,
        S_CALC,
        S_FINISH,
        S_EMIT_RD,
        S_EMIT_WAIT,
        S_OUT
    } state_t;

endpackage

/* sv/fmbs_occ_mem.sv */
// occurrence table memory: one wide word of counts per sorted row
// depends on nothing but its parameters
module fmbs_occ_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 88
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/fmbs_pos_mem.sv */
// suffix array store: text position of each sorted row
// depends on fmbs_pkg for the position width
module fmbs_pos_mem #(
    parameter int DEPTH = fmbs_pkg::ROWS_DEF
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [fmbs_pkg::POS_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [fmbs_pkg::POS_W-1:0] rd_data
);

    logic [fmbs_pkg::POS_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/fm_index_backward_search_core.sv */
// top level of the fm-index backward search core: control, counters, range logic
// depends on fmbs_pkg, fmbs_occ_mem and fmbs_pos_mem
//
// usage: load the sorted rows first, row 0 first, one row per item (tuser 0); load
// items leave the core idle. then feed pattern symbols last to first (tuser 1), with
// tlast on the pattern's first symbol. a live symbol passes idle, rd_hi and calc: two
// dependent reads of the occurrence memory, then the range update; a symbol out of
// range or absent from the index, or one that meets a dead search, marks the search
// dead with no read. after the final symbol the core walks the match range through the
// position memory, up to MAX_HITS hits, each read, awaited and held until the sink is
// ready; a run with no match gives one item with match_valid low. the core takes no new
// item while a run is being emitted. writing row_count resets the range and dead flag.
module fm_index_backward_search_core #(
    parameter int ROWS     = fmbs_pkg::ROWS_DEF,
    parameter int SYMBOLS  = fmbs_pkg::SYMBOLS_DEF,
    parameter int MAX_HITS = fmbs_pkg::MAX_HITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input items
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // row_index[9:0], text_position[19:10], first_symbol[22:20],
    // preceding_symbol[25:23], pattern_symbol[28:26], zero fill
    input  logic [31:0]                s_tdata,
    input  logic                       s_tuser,   // req_type
    input  logic                       s_tlast,   // pattern_last
    // result items
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,   // match_position[9:0], zero fill
    output logic [1:0]                 m_tuser,   // match_valid[0], truncated[1]
    output logic                       m_tlast,   // result_last
    // row_count register
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [fmbs_pkg::CFG_W-1:0] cfg_data
);

    localparam int IW = $clog2(ROWS);          // row index into memories
    localparam int CW = $clog2(ROWS + 1);      // saturating count
    localparam int SW = $clog2(SYMBOLS);       // symbol index
    localparam int RW = $clog2(ROWS) + 3;      // signed range bound
    localparam int KW = $clog2(MAX_HITS + 1);  // hit counter
    localparam int OW = SYMBOLS * CW;          // one occurrence row
    localparam logic signed [RW-1:0] ROWS_S  = RW'(ROWS);
    localparam logic signed [RW-1:0] HITS_S  = RW'(MAX_HITS);
    localparam logic        [CW-1:0] CNT_MAX = CW'(ROWS);

    // input fields
    logic [fmbs_pkg::ROW_W-1:0] row_index;
    logic [fmbs_pkg::POS_W-1:0] text_position;
    logic [fmbs_pkg::SYM_W-1:0] first_symbol, preceding_symbol, pattern_symbol;

    assign row_index        = s_tdata[9:0];
    assign text_position    = s_tdata[19:10];
    assign first_symbol     = s_tdata[22:20];
    assign preceding_symbol = s_tdata[25:23];
    assign pattern_symbol   = s_tdata[28:26];

    // state
    fmbs_pkg::state_t state_reg, state_next;
    logic signed [RW-1:0] row_count_reg, row_count_next;
    logic [CW-1:0] counts_reg [SYMBOLS];
    logic [CW-1:0] counts_next [SYMBOLS];
    logic [IW-1:0] sym_start_reg [SYMBOLS];
    logic [SYMBOLS-1:0] present_reg, present_next;
    logic prev_valid_reg, prev_valid_next;
    logic [fmbs_pkg::SYM_W-1:0] prev_sym_reg, prev_sym_next;
    logic signed [RW-1:0] range_low_reg, range_low_next;
    logic signed [RW-1:0] range_high_reg, range_high_next;
    logic dead_reg, dead_next;
    logic [SW-1:0] sym_reg, sym_next;
    logic last_reg, last_next;
    logic occ_ok_reg, occ_ok_next;
    logic [CW-1:0] occ_lo_reg, occ_lo_next;
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] emit_reg, emit_next;
    logic trunc_reg, trunc_next;
    logic pos_ok_reg, pos_ok_next;
    logic out_valid_reg, out_valid_next;
    logic [fmbs_pkg::POS_W-1:0] out_pos_reg, out_pos_next;
    logic out_match_reg, out_match_next;
    logic out_last_reg, out_last_next;
    logic out_trunc_reg, out_trunc_next;

    // memory ports
    logic          occ_wr_en, occ_rd_en;
    logic [IW-1:0] occ_wr_addr, occ_rd_addr;
    logic [OW-1:0] occ_wr_data, occ_rd_data;
    logic          pos_wr_en, pos_rd_en;
    logic [IW-1:0] pos_wr_addr, pos_rd_addr;
    logic [fmbs_pkg::POS_W-1:0] pos_rd_data;

    // symbol start write
    logic          start_wr_en;
    logic [SW-1:0] start_wr_sym;
    logic [IW-1:0] start_wr_val;

    fmbs_occ_mem #(.DEPTH(ROWS), .WIDTH(OW)) u_occ (
        .aclk    (aclk),
        .wr_en   (occ_wr_en),
        .wr_addr (occ_wr_addr),
        .wr_data (occ_wr_data),
        .rd_en   (occ_rd_en),
        .rd_addr (occ_rd_addr),
        .rd_data (occ_rd_data)
    );

    fmbs_pos_mem #(.DEPTH(ROWS)) u_pos (
        .aclk    (aclk),
        .wr_en   (pos_wr_en),
        .wr_addr (pos_wr_addr),
        .wr_data (text_position),
        .rd_en   (pos_rd_en),
        .rd_addr (pos_rd_addr),
        .rd_data (pos_rd_data)
    );

    assign s_tready  = (state_reg == fmbs_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(16 - fmbs_pkg::POS_W){1'b0}}, out_pos_reg};
    assign m_tuser   = {out_trunc_reg, out_match_reg};
    assign m_tlast   = out_last_reg;

    // decoded input values, widened so range checks work for any parameter value
    logic [16:0] row_w;
    logic [8:0]  fs_w, ps_w, pat_w;
    logic        load_ok, row_zero, first_changed;
    logic [SW-1:0] fs_i, ps_i, pat_i;
    logic [CW-1:0] occ_sel;
    logic signed [RW-1:0] occ_row, new_lo, new_hi, total, hit_row, base_s;
    logic [31:0] cfg_w;

    always_comb begin
        row_w    = 17'(row_index);
        fs_w     = 9'(first_symbol);
        ps_w     = 9'(preceding_symbol);
        pat_w    = 9'(pattern_symbol);
        fs_i     = fs_w[SW-1:0];
        ps_i     = ps_w[SW-1:0];
        pat_i    = pat_w[SW-1:0];
        load_ok  = (32'(row_w) < ROWS) && (32'(fs_w) < SYMBOLS) && (32'(ps_w) < SYMBOLS);
        row_zero = (row_index == '0);
        cfg_w    = 32'(cfg_data);
        occ_sel  = occ_rd_data[sym_reg * CW +: CW];
        base_s   = RW'(sym_start_reg[sym_reg]);

        state_next      = state_reg;
        row_count_next  = row_count_reg;
        counts_next     = counts_reg;
        present_next    = present_reg;
        prev_valid_next = prev_valid_reg;
        prev_sym_next   = prev_sym_reg;
        range_low_next  = range_low_reg;
        range_high_next = range_high_reg;
        dead_next       = dead_reg;
        sym_next        = sym_reg;
        last_next       = last_reg;
        occ_ok_next     = occ_ok_reg;
        occ_lo_next     = occ_lo_reg;
        k_next          = k_reg;
        emit_next       = emit_reg;
        trunc_next      = trunc_reg;
        pos_ok_next     = pos_ok_reg;
        out_valid_next  = out_valid_reg;
        out_pos_next    = out_pos_reg;
        out_match_next  = out_match_reg;
        out_last_next   = out_last_reg;
        out_trunc_next  = out_trunc_reg;

        occ_wr_en     = 1'b0;
        occ_wr_addr   = row_w[IW-1:0];
        occ_wr_data   = '0;
        occ_rd_en     = 1'b0;
        occ_row       = range_low_reg;
        pos_wr_en     = 1'b0;
        pos_wr_addr   = row_w[IW-1:0];
        pos_rd_en     = 1'b0;
        hit_row       = range_low_reg + RW'(k_reg);
        pos_rd_addr   = hit_row[IW-1:0];
        start_wr_en   = 1'b0;
        start_wr_sym  = fs_i;
        start_wr_val  = row_w[IW-1:0];
        first_changed = 1'b0;
        new_lo        = '0;
        new_hi        = '0;
        total         = range_high_reg - range_low_reg + RW'(1);

        case (state_reg)
            fmbs_pkg::S_IDLE: begin
                if (s_tvalid && s_tuser == fmbs_pkg::REQ_LOAD && load_ok) begin
                    // row zero starts a new index
                    if (row_zero) begin
                        for (int s = 0; s < SYMBOLS; s++) begin
                            counts_next[s] = '0;
                        end
                        present_next    = '0;
                        range_low_next  = '0;
                        range_high_next = row_count_reg - RW'(1);
                        dead_next       = 1'b0;
                    end
                    first_changed = row_zero || !prev_valid_reg || (prev_sym_reg != first_symbol);
                    if (first_changed) begin
                        start_wr_en      = 1'b1;
                        present_next[fs_i] = 1'b1;
                    end
                    prev_valid_next = 1'b1;
                    prev_sym_next   = first_symbol;
                    if (counts_next[ps_i] < CNT_MAX) begin
                        counts_next[ps_i] = counts_next[ps_i] + CW'(1);
                    end
                    for (int s = 0; s < SYMBOLS; s++) begin
                        occ_wr_data[s * CW +: CW] = counts_next[s];
                    end
                    occ_wr_en = 1'b1;
                    pos_wr_en = 1'b1;
                end else if (s_tvalid && s_tuser == fmbs_pkg::REQ_PATTERN) begin
                    sym_next  = pat_i;
                    last_next = s_tlast;
                    if (!dead_reg && (32'(pat_w) < SYMBOLS) && present_reg[pat_i]) begin
                        occ_rd_en   = 1'b1;
                        occ_ok_next = (occ_row >= RW'(1)) && (occ_row <= ROWS_S);
                        state_next  = fmbs_pkg::S_RD_HI;
                    end else begin
                        dead_next  = 1'b1;
                        state_next = s_tlast ? fmbs_pkg::S_FINISH : fmbs_pkg::S_IDLE;
                    end
                end
            end
            fmbs_pkg::S_RD_HI: begin
                occ_lo_next = occ_ok_reg ? occ_sel : '0;
                occ_row     = range_high_reg + RW'(1);
                occ_rd_en   = 1'b1;
                occ_ok_next = (occ_row >= RW'(1)) && (occ_row <= ROWS_S);
                state_next  = fmbs_pkg::S_CALC;
            end
            fmbs_pkg::S_CALC: begin
                new_lo          = base_s + RW'(occ_lo_reg);
                new_hi          = base_s + RW'(occ_ok_reg ? occ_sel : '0) - RW'(1);
                range_low_next  = new_lo;
                range_high_next = new_hi;
                dead_next       = (new_lo > new_hi);
                state_next      = last_reg ? fmbs_pkg::S_FINISH : fmbs_pkg::S_IDLE;
            end
            fmbs_pkg::S_FINISH: begin
                k_next = '0;
                if (dead_reg) begin
                    out_valid_next = 1'b1;
                    out_pos_next   = '0;
                    out_match_next = 1'b0;
                    out_last_next  = 1'b1;
                    out_trunc_next = 1'b0;
                    state_next     = fmbs_pkg::S_OUT;
                end else begin
                    trunc_next = (total > HITS_S);
                    emit_next  = (total > HITS_S) ? KW'(MAX_HITS) : total[KW-1:0];
                    state_next = fmbs_pkg::S_EMIT_RD;
                end
            end
            fmbs_pkg::S_EMIT_RD: begin
                // rows past the table read as position zero
                pos_ok_next = (hit_row < ROWS_S);
                pos_rd_en   = pos_ok_next;
                state_next  = fmbs_pkg::S_EMIT_WAIT;
            end
            fmbs_pkg::S_EMIT_WAIT: begin
                out_valid_next = 1'b1;
                out_pos_next   = pos_ok_reg ? pos_rd_data : '0;
                out_match_next = 1'b1;
                out_last_next  = (k_reg == emit_reg - KW'(1));
                out_trunc_next = trunc_reg;
                state_next     = fmbs_pkg::S_OUT;
            end
            fmbs_pkg::S_OUT: begin
                if (m_tready) begin
                    out_valid_next = 1'b0;
                    if (out_last_reg) begin
                        range_low_next  = '0;
                        range_high_next = row_count_reg - RW'(1);
                        dead_next       = 1'b0;
                        state_next      = fmbs_pkg::S_IDLE;
                    end else begin
                        k_next     = k_reg + KW'(1);
                        state_next = fmbs_pkg::S_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = fmbs_pkg::S_IDLE;
            end
        endcase

        occ_rd_addr = occ_row[IW-1:0] - IW'(1);

        // row_count write saturates at the table size and restarts the range
        if (cfg_valid) begin
            row_count_next  = (cfg_w > 32'(ROWS)) ? ROWS_S : RW'(cfg_w);
            range_low_next  = '0;
            range_high_next = row_count_next - RW'(1);
            dead_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= fmbs_pkg::S_IDLE;
            row_count_reg  <= RW'(1);
            for (int s = 0; s < SYMBOLS; s++) begin
                counts_reg[s] <= '0;
            end
            present_reg    <= '0;
            prev_valid_reg <= 1'b0;
            range_low_reg  <= '0;
            range_high_reg <= '0;
            dead_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            row_count_reg  <= row_count_next;
            counts_reg     <= counts_next;
            present_reg    <= present_next;
            prev_valid_reg <= prev_valid_next;
            range_low_reg  <= range_low_next;
            range_high_reg <= range_high_next;
            dead_reg       <= dead_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        prev_sym_reg  <= prev_sym_next;
        sym_reg       <= sym_next;
        last_reg      <= last_next;
        occ_ok_reg    <= occ_ok_next;
        occ_lo_reg    <= occ_lo_next;
        k_reg         <= k_next;
        emit_reg      <= emit_next;
        trunc_reg     <= trunc_next;
        pos_ok_reg    <= pos_ok_next;
        out_pos_reg   <= out_pos_next;
        out_match_reg <= out_match_next;
        out_last_reg  <= out_last_next;
        out_trunc_reg <= out_trunc_next;
        if (start_wr_en) begin
            sym_start_reg[start_wr_sym] <= start_wr_val;
        end
    end

`ifndef ASSERT_OFF
    a_valid_only_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> state_reg == fmbs_pkg::S_OUT)
        else $error("result item shown outside output state");

    a_nomatch_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && !m_tuser[1]))
        else $error("no-match item not a lone final item");

    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fmbs_pkg::S_EMIT_RD) |-> (k_reg < emit_reg))
        else $error("hit counter past emit count");

    a_symbol_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == fmbs_pkg::REQ_PATTERN && s_tlast)
        |=> state_reg != fmbs_pkg::S_IDLE)
        else $error("final pattern symbol did not start emission");
`endif

endmodule
